FILE: hw/rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: field widths, limits,
// transaction kinds and the packed layout of one job-slot table entry.
// No dependencies.
`default_nettype none

package pps_pkg;

	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int TIME_W   = 16;
	localparam int PRIO_W   = 10;
	localparam int COUNT_W  = 5;
	localparam int ACTIVE_W = 5;

	localparam logic [PRIO_W-1:0]   PRIO_CUTOFF    = 10'd999;
	localparam logic [TIME_W-1:0]   TIME_MAX       = 16'hFFFF;
	localparam logic [COUNT_W-1:0]  COUNT_MAX      = 5'd31;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 5'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	// One job slot as held in the table RAM.
	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] remaining;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: hw/rtl/pps_if.sv
// Channel interfaces of the preemptive priority scheduler: command,
// report and configuration write. Depends on pps_pkg.
`default_nettype none

interface pps_cmd_if import pps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] slot_index;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] burst_length;
	logic [PRIO_W-1:0] job_priority;

	modport source (output valid, kind, slot_index, arrival_time, burst_length, job_priority,
		input ready);
	modport sink (input valid, kind, slot_index, arrival_time, burst_length, job_priority,
		output ready);
endinterface

interface pps_rpt_if import pps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              idle;
	logic [SLOT_W-1:0] chosen_slot;
	logic              finished;
	logic [TIME_W-1:0] completion_time;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] waiting;
	logic              all_done;

	modport source (output valid, idle, chosen_slot, finished, completion_time, turnaround,
		waiting, all_done, input ready);
	modport sink (input valid, idle, chosen_slot, finished, completion_time, turnaround,
		waiting, all_done, output ready);
endinterface

interface pps_cfg_if import pps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTIVE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/priority_preemptive_scheduler.sv
// Preemptive priority scheduler, top level: job-slot table in a RAM,
// scan sequencer and report register. Depends on pps_pkg, pps_if, pps_ram.
//
// Usage:
//  cfg : write transaction sets active_slots (slots 0..n-1 take part; values
//        above SLOTS act as SLOTS, zero means every tick is idle). Always ready.
//  cmd : one transaction per command. kind load writes a slot (ignored for
//        slot_index >= SLOTS), restart clears time and completion count, tick
//        schedules one unit of service.
//  rpt : one report per tick, none for other kinds.
//  Tick: n = effective active count. The single RAM read port sets the steps:
//        the scan reads one slot per cycle, a drain state waits for the
//        registered read data, then the update state writes back and loads
//        the report. With n zero the scan and the drain are skipped.
//  cmd.ready is high only while the sequencer is waiting for a command.
//  Stall: the report sits in an output register; a finished tick waits in
//        its update cycle only while a previous report is still not taken.
//  Reset: active_slots = 4, time and count zero, every slot reads as empty
//        (per-slot valid flops; RAM contents need no clearing pass).
`default_nettype none

module priority_preemptive_scheduler
	import pps_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pps_cfg_if.sink  cfg,
	pps_cmd_if.sink  cmd,
	pps_rpt_if.source rpt
);

	localparam int ADDR_W = $clog2(SLOTS);
	// Largest useful active count, limited to what the register can hold.
	localparam logic [ACTIVE_W-1:0] SLOTS_CAP =
		(SLOTS > 31) ? 5'd31 : ACTIVE_W'(SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [TIME_W-1:0]   time_q;
	logic [COUNT_W-1:0]  count_q;
	// Set by a load; a slot never loaded is never eligible.
	logic [SLOTS-1:0]    loaded_q;
	// A done mark always goes with zero remaining time, so the remaining
	// count stands in for it in the eligibility test.

	logic [ACTIVE_W-1:0] scan_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                found_q;
	logic [ADDR_W-1:0]   pick_q;
	entry_t              best_q;

	logic                out_valid_q;
	logic                idle_q;
	logic [SLOT_W-1:0]   chosen_q;
	logic                fin_q;
	logic [TIME_W-1:0]   ct_q;
	logic [TIME_W-1:0]   tat_q;
	logic [TIME_W-1:0]   wt_q;
	logic                all_done_q;

	// Effective active count.
	logic [ACTIVE_W-1:0] n_eff;
	assign n_eff = (active_q > SLOTS_CAP) ? SLOTS_CAP : active_q;

	// Address conversions between the fixed field widths and ADDR_W.
	logic [ADDR_W+SLOT_W-1:0]   ld_wide;
	logic [ADDR_W+ACTIVE_W-1:0] scan_wide;
	logic [ADDR_W+SLOT_W-1:0]   pick_wide;
	logic [ADDR_W-1:0]          ld_addr;
	logic [ADDR_W-1:0]          scan_addr;
	logic                       ld_in_range;

	assign ld_wide     = {{ADDR_W{1'b0}}, cmd.slot_index};
	assign scan_wide   = {{ADDR_W{1'b0}}, scan_q};
	assign pick_wide   = {{SLOT_W{1'b0}}, pick_q};
	assign ld_addr     = ld_wide[ADDR_W-1:0];
	assign scan_addr   = scan_wide[ADDR_W-1:0];
	assign ld_in_range = 32'(cmd.slot_index) < SLOTS;

	logic cmd_fire;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	// Update step of a tick: free to complete once the report register is free.
	logic fin_go;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || rpt.ready);

	// Scan compare on the entry read the cycle before.
	entry_t rd_data;
	logic   eligible;
	assign eligible = rd_vld_s1 && loaded_q[addr_s1] && (rd_data.remaining != '0) &&
		(rd_data.arrival <= time_q) && (rd_data.prio < best_q.prio);

	// Tick arithmetic.
	logic [TIME_W-1:0]  time_next;
	logic [TIME_W-1:0]  rem_next;
	logic               fin_now;
	logic [TIME_W-1:0]  tat_now;
	logic [TIME_W-1:0]  wt_now;
	logic [COUNT_W-1:0] count_next;

	always_comb begin
		time_next  = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
		rem_next   = best_q.remaining - 1'b1;
		fin_now    = found_q && (rem_next == '0);
		tat_now    = time_next - best_q.arrival;
		wt_now     = (tat_now >= best_q.burst) ? tat_now - best_q.burst : '0;
		count_next = (fin_now && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	end

	// RAM ports: loads write in the idle state, the update step writes the
	// chosen slot back. The FSM keeps that write after every scan read, so
	// no forwarding is needed.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ld_addr;
		ram_wdata = '{arrival: cmd.arrival_time, burst: cmd.burst_length,
			prio: cmd.job_priority, remaining: cmd.burst_length};
		if (cmd_fire && kind_t'(cmd.kind) == KIND_LOAD && ld_in_range) begin
			ram_we = 1'b1;
		end else if (fin_go && found_q) begin
			ram_we              = 1'b1;
			ram_waddr           = pick_q;
			ram_wdata           = best_q;
			ram_wdata.remaining = rem_next;
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	pps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= ACTIVE_RESET;
			time_q      <= '0;
			count_q     <= '0;
			loaded_q    <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			addr_s1     <= '0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			idle_q      <= 1'b0;
			chosen_q    <= '0;
			fin_q       <= 1'b0;
			ct_q        <= '0;
			tat_q       <= '0;
			wt_q        <= '0;
			all_done_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				active_q <= cfg.data;
			end
			// A report taken in the update cycle is replaced there.
			if (out_valid_q && rpt.ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= ram_re;
			addr_s1   <= scan_addr;
			if (eligible) begin
				found_q <= 1'b1;
				pick_q  <= addr_s1;
				best_q  <= rd_data;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (kind_t'(cmd.kind))
							KIND_LOAD: begin
								if (ld_in_range) begin
									loaded_q[ld_addr] <= 1'b1;
								end
							end
							KIND_RESTART: begin
								time_q  <= '0;
								count_q <= '0;
							end
							KIND_TICK: begin
								scan_q  <= '0;
								found_q <= 1'b0;
								best_q  <= '{arrival: '0, burst: '0, prio: PRIO_CUTOFF,
									remaining: '0};
								state_q <= (n_eff == '0) ? ST_FIN : ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == n_eff - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						time_q      <= time_next;
						count_q     <= count_next;
						out_valid_q <= 1'b1;
						idle_q      <= !found_q;
						chosen_q    <= found_q ? pick_wide[SLOT_W-1:0] : '0;
						fin_q       <= fin_now;
						ct_q        <= fin_now ? time_next : '0;
						tat_q       <= fin_now ? tat_now : '0;
						wt_q        <= fin_now ? wt_now : '0;
						all_done_q  <= (count_next >= n_eff);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rpt.valid           = out_valid_q;
	assign rpt.idle            = idle_q;
	assign rpt.chosen_slot     = chosen_q;
	assign rpt.finished        = fin_q;
	assign rpt.completion_time = ct_q;
	assign rpt.turnaround      = tat_q;
	assign rpt.waiting         = wt_q;
	assign rpt.all_done        = all_done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: bench/priority_preemptive_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for priority_preemptive_scheduler: load/tick/restart traffic,
// an in-bench scheduler predictor and a report scoreboard.
// Depends on pps_pkg, pps_if and the scheduler RTL.

module priority_preemptive_scheduler_tb;
	import pps_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int QUIET_LIMIT = 2000;   // cycles with no transaction anywhere
	localparam int SETTLE_CYCLES = 24;   // quiet wait after the last owed report
	localparam int PHASE_ITEMS = 130;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One tick report, laid out field by field.
	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] chosen_slot;
		logic              finished;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_done;
	} sched_report_t;

	// Scheduler predictor plus the queue of reports still owed by the DUT.
	class sched_scoreboard;
		logic [TIME_W-1:0]   arrival [NUM_SLOTS];
		logic [TIME_W-1:0]   burst [NUM_SLOTS];
		logic [PRIO_W-1:0]   prio [NUM_SLOTS];
		logic [TIME_W-1:0]   remaining [NUM_SLOTS];
		bit                  done_mark [NUM_SLOTS];
		logic [TIME_W-1:0]   now;
		logic [COUNT_W-1:0]  completions;
		logic [ACTIVE_W-1:0] active;
		sched_report_t       owed_reports [$];
		int                  errors;

		function new();
			foreach (arrival[i]) begin
				arrival[i] = '0;
				burst[i] = '0;
				prio[i] = '0;
				remaining[i] = '0;
				done_mark[i] = 1'b0;
			end
			now = '0;
			completions = '0;
			active = ACTIVE_RESET;
			errors = 0;
		endfunction

		function int slots_in_use();
			return (int'(active) > NUM_SLOTS) ? NUM_SLOTS : int'(active);
		endfunction

		// One unit of service: pick, advance time, retire on completion.
		function sched_report_t serve_tick();
			sched_report_t r;
			int n;
			int pick;
			bit found;
			logic [PRIO_W-1:0] best;
			r = '0;
			n = slots_in_use();
			pick = 0;
			found = 1'b0;
			best = PRIO_CUTOFF;
			for (int i = 0; i < n; i++) begin
				if (arrival[i] <= now && !done_mark[i] && remaining[i] != '0 &&
						prio[i] < best) begin
					best = prio[i];
					pick = i;
					found = 1'b1;
				end
			end
			if (now != TIME_MAX)
				now = now + 1'b1;
			if (found) begin
				remaining[pick] = remaining[pick] - 1'b1;
				if (remaining[pick] == '0) begin
					r.finished = 1'b1;
					r.completion_time = now;
					r.turnaround = now - arrival[pick];
					// restart or saturated time can leave turnaround below burst
					r.waiting = (r.turnaround >= burst[pick]) ?
						r.turnaround - burst[pick] : '0;
					done_mark[pick] = 1'b1;
					if (completions != COUNT_MAX)
						completions = completions + 1'b1;
				end
			end
			r.idle = !found;
			r.chosen_slot = found ? SLOT_W'(pick) : '0;
			r.all_done = (int'(completions) >= n);
			return r;
		endfunction

		function void note_command(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
				logic [TIME_W-1:0] arr, logic [TIME_W-1:0] len, logic [PRIO_W-1:0] pri);
			case (kind)
				KIND_LOAD: begin
					arrival[slot] = arr;
					burst[slot] = len;
					prio[slot] = pri;
					remaining[slot] = len;
					done_mark[slot] = 1'b0;
				end
				KIND_TICK: owed_reports.push_back(serve_tick());
				KIND_RESTART: begin
					now = '0;
					completions = '0;
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("[%0t] %s", $time, what);
		endtask

		task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
		endtask

		task check_report(sched_report_t got);
			sched_report_t want;
			if (owed_reports.size() == 0) begin
				report_mismatch("report with no tick outstanding");
				return;
			end
			want = owed_reports.pop_front();
			compare_field("idle", TIME_W'(got.idle), TIME_W'(want.idle));
			compare_field("chosen_slot", TIME_W'(got.chosen_slot), TIME_W'(want.chosen_slot));
			compare_field("finished", TIME_W'(got.finished), TIME_W'(want.finished));
			compare_field("completion_time", got.completion_time, want.completion_time);
			compare_field("turnaround", got.turnaround, want.turnaround);
			compare_field("waiting", got.waiting, want.waiting);
			compare_field("all_done", TIME_W'(got.all_done), TIME_W'(want.all_done));
		endtask

		task leftover_check();
			if (owed_reports.size() != 0)
				report_mismatch($sformatf("%0d tick reports never arrived",
					owed_reports.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pps_cmd_if cmd_ch ();
	pps_rpt_if rpt_ch ();
	pps_cfg_if cfg_ch ();

	priority_preemptive_scheduler #(
		.SLOTS (NUM_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rpt    (rpt_ch)
	);

	sched_scoreboard sb = new();

	// sender pacing: a burst counter, refilled after a random gap
	int burst_left = 0;
	int items_sent = 0;     // non-ignored command transactions

	// receiver pattern state
	logic [1:0] ready_mode = 2'd0;
	int         ready_hold = 0;
	logic [2:0] ready_phase = 3'd0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: switches at random between always-ready, toggling, random and
	// one-in-eight patterns.
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_mode <= 2'($urandom_range(0, 3));
			ready_hold <= $urandom_range(20, 80);
		end else begin
			ready_hold <= ready_hold - 1;
		end
		ready_phase <= ready_phase + 1'b1;
		case (ready_mode)
			2'd0: rpt_ch.ready <= 1'b1;
			2'd1: rpt_ch.ready <= !rpt_ch.ready;
			2'd2: rpt_ch.ready <= ($urandom_range(0, 3) != 0);
			default: rpt_ch.ready <= (ready_phase == 3'd0);
		endcase
	end

	// Report monitor: every accepted report transaction is checked in order.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rpt_ch.valid && rpt_ch.ready)
			sb.check_report({rpt_ch.idle, rpt_ch.chosen_slot, rpt_ch.finished,
				rpt_ch.completion_time, rpt_ch.turnaround, rpt_ch.waiting,
				rpt_ch.all_done});
	end

	// Watchdog: a long stretch without any transaction means a hang.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One command transaction. Valid stays high across back-to-back
	// transactions; it drops only for a sender gap or in quiesce.
	task automatic send_command(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
			logic [TIME_W-1:0] arr, logic [TIME_W-1:0] len, logic [PRIO_W-1:0] pri);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= kind;
		cmd_ch.slot_index <= slot;
		cmd_ch.arrival_time <= arr;
		cmd_ch.burst_length <= len;
		cmd_ch.job_priority <= pri;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		sb.note_command(kind, slot, arr, len, pri);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic load_slot(int slot, int arr, int len, int pri);
		send_command(KIND_LOAD, SLOT_W'(slot), TIME_W'(arr), TIME_W'(len), PRIO_W'(pri));
	endtask

	// Unused fields of a non-load carry random junk; the DUT must ignore it.
	task automatic send_other(logic [KIND_W-1:0] kind);
		send_command(kind, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
			PRIO_W'($urandom));
	endtask

	// Drop valid, collect every owed report, then let the sequencer settle.
	task automatic quiesce();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.owed_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active(logic [ACTIVE_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.active = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly jobs that arrive soon with short bursts and a few competing
	// priorities; now and then full-range noise, the cutoff band or zero burst.
	task automatic random_load();
		int n;
		int slot;
		int arr;
		int len;
		int pri;
		n = sb.slots_in_use();
		slot = (n == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_SLOTS - 1) :
			$urandom_range(0, n - 1);
		arr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) :
			int'(sb.now) + $urandom_range(0, 6);
		case ($urandom_range(0, 29))
			0: len = 0;
			1: len = $urandom_range(0, 65535);
			2, 3: len = $urandom_range(6, 40);
			default: len = $urandom_range(1, 5);
		endcase
		case ($urandom_range(0, 11))
			0: pri = $urandom_range(999, 1023);
			1, 2, 3, 4: pri = $urandom_range(0, 998);
			default: pri = $urandom_range(0, 7);   // plenty of ties
		endcase
		load_slot(slot, arr, len, pri);
	endtask

	// A small job set, then a run of ticks with the odd preempting load,
	// restart or unused-kind transaction mixed in.
	task automatic run_episode();
		int loads;
		int ticks;
		loads = $urandom_range(1, 4);
		ticks = $urandom_range(2, 14);
		repeat (loads) random_load();
		repeat (ticks) begin
			case ($urandom_range(0, 39))
				0: send_other(KIND_RESTART);
				1: send_other(KIND_UNUSED);
				2, 3, 4: random_load();
				default: ;
			endcase
			send_other(KIND_TICK);
		end
	endtask

	initial begin
		logic [ACTIVE_W-1:0] phase_active [7];
		phase_active = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd16};
		phase_active[4] = ACTIVE_W'($urandom_range(2, 15));

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_LOAD;
		cmd_ch.slot_index = '0;
		cmd_ch.arrival_time = '0;
		cmd_ch.burst_length = '0;
		cmd_ch.job_priority = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rpt_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset width of four slots.
		send_other(KIND_TICK);            // empty table: idle
		load_slot(0, 0, 2, 5);
		load_slot(1, 0, 1, 5);            // same priority as slot 0: lower index wins
		load_slot(2, 0, 0, 0);            // zero burst, never picked
		load_slot(3, 0, 1, 999);          // at the cutoff, never picked
		load_slot(5, 0, 1, 0);            // outside the active slots
		send_other(KIND_UNUSED);
		send_other(KIND_TICK);
		load_slot(1, 0, 1, 0);            // reload with better priority preempts slot 0
		send_other(KIND_TICK);
		send_other(KIND_TICK);
		send_other(KIND_TICK);            // nothing eligible left
		load_slot(3, 65535, 65535, 1023);
		load_slot(15, 65535, 65535, 998);
		load_slot(2, 0, 3, 0);
		send_other(KIND_TICK);
		send_other(KIND_TICK);
		send_other(KIND_RESTART);
		send_other(KIND_TICK);            // finishes with turnaround below burst
		load_slot(2, 5, 1, 0);            // arrives later
		send_other(KIND_TICK);
		quiesce();

		// Random part, one active-slot setting per phase.
		items_sent = 0;
		foreach (phase_active[p]) begin
			write_active(phase_active[p]);
			while (items_sent < (p + 1) * PHASE_ITEMS)
				run_episode();
			quiesce();
		end

		sb.leftover_check();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
